// ===== rtl/core/ascii_unsigned_integer_parser_top_assert.svh =====
// Assertion macros used by the parser top level.
`ifndef ASCII_UNSIGNED_INTEGER_PARSER_TOP_ASSERT_SVH
`define ASCII_UNSIGNED_INTEGER_PARSER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AUIP_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("auip check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define AUIP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("auip check failed: next-cycle implication");

`endif

// ===== rtl/core/auip_pkg.sv =====
`timescale 1ns / 1ps

package auip_pkg;

    // Parse phases.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LEAD   = 3'd1;
    localparam logic [2:0] PH_SIGNED = 3'd2;
    localparam logic [2:0] PH_ZERO   = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;

    // Radix field width and the fixed radix values used by prefix detection.
    localparam int unsigned BASE_W = 6;
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    // Characters with a special role.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Marks a byte that is no digit symbol at all.
    localparam logic [7:0] NO_DIGIT = 8'hFF;

    // Conversion control state carried between the step logic and its registers.
    typedef struct packed {
        logic [2:0]        phase;
        logic [BASE_W-1:0] base;
        logic              minus;
        logic              digit;
        logic              ovf;
    } t_ctl;

    // Value of a digit symbol 0-9, A-Z, a-z, or NO_DIGIT.
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        v = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c - CH_ZERO;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            v = c - (CH_UP_A - 8'd10);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            v = c - (CH_LO_A - 8'd10);
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/auip_in_reg.sv =====
`timescale 1ns / 1ps

module auip_in_reg import auip_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_sot,
    input  logic       i_eot,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_sot,
    output logic       o_eot
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_sot;
    logic       r_eot;
    logic       w_load;

    // The slot frees up in the same cycle its word moves on.
    assign o_ready = !r_valid || i_take;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_byte;
            r_sot  <= i_sot;
            r_eot  <= i_eot;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_sot   = r_sot;
    assign o_eot   = r_eot;

endmodule

// ===== rtl/core/auip_step.sv =====
`timescale 1ns / 1ps

module auip_step import auip_pkg::*; #(
    parameter int unsigned VALUE_WIDTH  = 64,
    parameter int unsigned OFFSET_WIDTH = 16
) (
    input  t_ctl                    i_ctl,
    input  logic [VALUE_WIDTH-1:0]  i_acc,
    input  logic [OFFSET_WIDTH-1:0] i_cnt,
    input  logic [BASE_W-1:0]       i_number_base,
    input  logic [7:0]              i_byte,
    input  logic                    i_sot,
    input  logic                    i_eot,
    output t_ctl                    o_ctl,
    output logic [VALUE_WIDTH-1:0]  o_acc,
    output logic [OFFSET_WIDTH-1:0] o_cnt,
    output logic                    o_emit,
    output logic [VALUE_WIDTH-1:0]  o_result_value,
    output logic                    o_any_digits,
    output logic [OFFSET_WIDTH-1:0] o_end_offset,
    output logic                    o_wrapped
);

    localparam int unsigned PROD_W = VALUE_WIDTH + BASE_W;

    t_ctl                    s;
    logic [VALUE_WIDTH-1:0]  acc;
    logic [OFFSET_WIDTH-1:0] cnt;
    logic [2:0]              ph;
    logic [BASE_W-1:0]       eb;
    logic [7:0]              d;
    logic [PROD_W-1:0]       prod;
    logic                    first;
    logic                    try_digit;
    logic                    cnt_inc;
    logic                    done;
    logic                    emit;

    always_comb begin
        s         = i_ctl;
        acc       = i_acc;
        cnt       = i_cnt;
        first     = 1'b0;
        try_digit = 1'b0;
        cnt_inc   = 1'b0;
        done      = 1'b0;
        emit      = 1'b0;

        // A start marker drops any running conversion and latches the radix.
        if (i_sot) begin
            s       = '0;
            s.base  = i_number_base;
            s.phase = PH_LEAD;
            acc     = '0;
            cnt     = '0;
        end
        ph = s.phase;
        eb = s.base;

        // Phase handling for whitespace, sign and prefix.
        case (ph)
            PH_LEAD: begin
                if (i_byte == CH_SPACE || (i_byte inside {[CH_TAB:CH_CR]})) begin
                    cnt_inc = 1'b1;
                end else if (i_byte == CH_MINUS || i_byte == CH_PLUS) begin
                    s.minus = (i_byte == CH_MINUS);
                    cnt_inc = 1'b1;
                    s.phase = PH_SIGNED;
                end else begin
                    first = 1'b1;
                end
            end
            PH_SIGNED: begin
                first = 1'b1;
            end
            PH_ZERO: begin
                if (i_byte == CH_LO_X || i_byte == CH_UP_X) begin
                    cnt_inc = 1'b1;
                    s.base  = BASE_HEX;
                    s.phase = PH_DIGITS;
                end else begin
                    eb        = (s.base == BASE_AUTO) ? BASE_OCT : s.base;
                    s.base    = eb;
                    s.digit   = 1'b1;
                    s.phase   = PH_DIGITS;
                    try_digit = 1'b1;
                end
            end
            PH_DIGITS: begin
                try_digit = 1'b1;
            end
            default: begin
            end
        endcase

        // First significant byte: a leading zero may open a hex prefix.
        if (first) begin
            if ((s.base == BASE_AUTO || s.base == BASE_HEX) && i_byte == CH_ZERO) begin
                cnt_inc = 1'b1;
                s.phase = PH_ZERO;
            end else begin
                eb        = (s.base == BASE_AUTO) ? BASE_DEC : s.base;
                s.base    = eb;
                s.phase   = PH_DIGITS;
                try_digit = 1'b1;
            end
        end

        // One multiply-add per digit; bits above the value width flag a wrap.
        d    = digit_value(i_byte);
        prod = PROD_W'(acc) * PROD_W'(eb) + PROD_W'(d);
        if (try_digit) begin
            if (d == NO_DIGIT || d >= {2'b00, eb} || eb == BASE_AUTO) begin
                done = 1'b1;
            end else begin
                if (prod[PROD_W-1:VALUE_WIDTH] != '0) begin
                    s.ovf = 1'b1;
                end
                acc     = prod[VALUE_WIDTH-1:0];
                s.digit = 1'b1;
                cnt_inc = 1'b1;
            end
        end

        // Consumed-byte count saturates at all ones.
        if (cnt_inc && cnt != '1) begin
            cnt = cnt + 1'b1;
        end

        // A stop byte or the end marker completes an active conversion.
        if (ph != PH_IDLE) begin
            if (done) begin
                emit = 1'b1;
            end else if (i_eot) begin
                if (s.phase == PH_ZERO) begin
                    s.digit = 1'b1;
                end
                emit = 1'b1;
            end
        end
        if (emit) begin
            s.phase = PH_IDLE;
        end
    end

    assign o_ctl          = s;
    assign o_acc          = acc;
    assign o_cnt          = cnt;
    assign o_emit         = emit;
    assign o_result_value = s.minus ? (~acc + 1'b1) : acc;
    assign o_any_digits   = s.digit;
    assign o_end_offset   = s.digit ? cnt : '0;
    assign o_wrapped      = s.ovf;

endmodule

// ===== rtl/core/auip_out_reg.sv =====
`timescale 1ns / 1ps

module auip_out_reg import auip_pkg::*; #(
    parameter int unsigned VALUE_WIDTH  = 64,
    parameter int unsigned OFFSET_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic [VALUE_WIDTH-1:0]  i_result_value,
    input  logic                    i_any_digits,
    input  logic [OFFSET_WIDTH-1:0] i_end_offset,
    input  logic                    i_wrapped,
    input  logic                    i_ready,
    output logic                    o_free,
    output logic                    o_valid,
    output logic [VALUE_WIDTH-1:0]  o_result_value,
    output logic                    o_any_digits,
    output logic [OFFSET_WIDTH-1:0] o_end_offset,
    output logic                    o_wrapped
);

    logic                    r_valid;
    logic [VALUE_WIDTH-1:0]  r_value;
    logic                    r_any;
    logic [OFFSET_WIDTH-1:0] r_offset;
    logic                    r_wrapped;

    // The register can take a new word when empty or when its word leaves now.
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value   <= i_result_value;
            r_any     <= i_any_digits;
            r_offset  <= i_end_offset;
            r_wrapped <= i_wrapped;
        end
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_value;
    assign o_any_digits   = r_any;
    assign o_end_offset   = r_offset;
    assign o_wrapped      = r_wrapped;

endmodule

// ===== rtl/core/ascii_unsigned_integer_parser_top.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                  Word
// input     i_in_valid / o_in_ready    i_text_byte, i_start_of_text, i_end_of_text
// output    o_out_valid / i_out_ready  o_result_value, o_any_digits, o_end_offset, o_wrapped
// config    i_cfg_we                   i_cfg_wdata (number base)
//
// One byte per cycle while the result register can take a word: a word is held in the
// input register, then one multiply-add of the accumulator by the radix updates the state
// and loads the result register when the byte ends the conversion.
// Reset is synchronous and active low; it clears the radix and the parse state.
// While a result waits, no byte is processed and the input register holds at most one byte.

module ascii_unsigned_integer_parser_top import auip_pkg::*; #(
    parameter int unsigned VALUE_WIDTH  = 64,
    parameter int unsigned OFFSET_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [BASE_W-1:0]       i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [7:0]              i_text_byte,
    input  logic                    i_start_of_text,
    input  logic                    i_end_of_text,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [VALUE_WIDTH-1:0]  o_result_value,
    output logic                    o_any_digits,
    output logic [OFFSET_WIDTH-1:0] o_end_offset,
    output logic                    o_wrapped
);

    logic [BASE_W-1:0]       r_number_base;
    t_ctl                    r_ctl;
    t_ctl                    n_ctl;
    logic [VALUE_WIDTH-1:0]  r_acc;
    logic [VALUE_WIDTH-1:0]  n_acc;
    logic [OFFSET_WIDTH-1:0] r_cnt;
    logic [OFFSET_WIDTH-1:0] n_cnt;

    logic                    w_in_valid;
    logic [7:0]              w_byte;
    logic                    w_sot;
    logic                    w_eot;
    logic                    w_out_free;
    logic                    w_fire;
    logic                    w_emit;
    logic [VALUE_WIDTH-1:0]  w_value;
    logic                    w_any;
    logic [OFFSET_WIDTH-1:0] w_offset;
    logic                    w_wrapped;
    logic                    w_empty_result;
    logic                    w_idle_byte;

    // Radix register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BASE_AUTO;
        end else if (i_cfg_we) begin
            r_number_base <= i_cfg_wdata;
        end
    end

    auip_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_text_byte),
        .i_sot   (i_start_of_text),
        .i_eot   (i_end_of_text),
        .i_take  (w_fire),
        .o_valid (w_in_valid),
        .o_byte  (w_byte),
        .o_sot   (w_sot),
        .o_eot   (w_eot)
    );

    // A held byte is processed whenever the result register can take a word.
    assign w_fire = w_in_valid && w_out_free;

    auip_step #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_step (
        .i_ctl          (r_ctl),
        .i_acc          (r_acc),
        .i_cnt          (r_cnt),
        .i_number_base  (r_number_base),
        .i_byte         (w_byte),
        .i_sot          (w_sot),
        .i_eot          (w_eot),
        .o_ctl          (n_ctl),
        .o_acc          (n_acc),
        .o_cnt          (n_cnt),
        .o_emit         (w_emit),
        .o_result_value (w_value),
        .o_any_digits   (w_any),
        .o_end_offset   (w_offset),
        .o_wrapped      (w_wrapped)
    );

    // Conversion state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
            r_acc <= '0;
            r_cnt <= '0;
        end else if (w_fire) begin
            r_ctl <= n_ctl;
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
    end

    auip_out_reg #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_out_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_fire && w_emit),
        .i_result_value (w_value),
        .i_any_digits   (w_any),
        .i_end_offset   (w_offset),
        .i_wrapped      (w_wrapped),
        .i_ready        (i_out_ready),
        .o_free         (w_out_free),
        .o_valid        (o_out_valid),
        .o_result_value (o_result_value),
        .o_any_digits   (o_any_digits),
        .o_end_offset   (o_end_offset),
        .o_wrapped      (o_wrapped)
    );

`include "ascii_unsigned_integer_parser_top_assert.svh"

    // Terms watched by the checks below.
    assign w_empty_result = o_out_valid && !o_any_digits;
    assign w_idle_byte    = w_fire && !w_sot && r_ctl.phase == PH_IDLE;

    // A result without digits always reports a zero offset.
    `AUIP_ASSERT_SAME(a_no_digit_offset, i_clk, i_rst_n, w_empty_result, o_end_offset == '0)

    // Input backpressure only comes from a held byte.
    `AUIP_ASSERT_SAME(a_ready_source, i_clk, i_rst_n, !o_in_ready, w_in_valid)

    // A byte outside a conversion never produces a result.
    `AUIP_ASSERT_NEXT(a_idle_silent, i_clk, i_rst_n, w_idle_byte, !o_out_valid)

endmodule
